// File: rtl/qpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared types and constants for the quaternion point rotation pipeline.
// ----------------------------------------------------------------------------
package qpr_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int TURN_UNITS = 92160;
    localparam int QUARTER_UNITS = 23040;
    localparam int RAD_PER_UNIT_Q30 = 73204;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Data that rides alongside the rotator cells
    typedef struct packed {
        quad_t             quad;
        logic signed [32:0] d_x;
        logic signed [32:0] d_y;
        logic signed [32:0] d_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
    } side_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } rot_t;

    function automatic logic signed [33:0] atan_q30(input int step);
        logic signed [33:0] r;
        begin
            case (step)
                0: r = 34'sd843314857;
                1: r = 34'sd497837829;
                2: r = 34'sd263043837;
                3: r = 34'sd133525159;
                4: r = 34'sd67021687;
                5: r = 34'sd33543516;
                6: r = 34'sd16775851;
                7: r = 34'sd8388437;
                8: r = 34'sd4194283;
                9: r = 34'sd2097149;
                default: r = 34'sd1 <<< (30 - step);
            endcase
            return r;
        end
    endfunction

endpackage

// File: rtl/qpr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpr_front
// Entry stage: reduce the half angle to quadrant and radians, form P - C.
// ----------------------------------------------------------------------------
module qpr_front
    import qpr_pkg::*;
#(
    parameter int CW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 v_in,
    input  logic [CW-1:0]        p_x,
    input  logic [CW-1:0]        p_y,
    input  logic [CW-1:0]        p_z,
    input  logic [CW-1:0]        k_x,
    input  logic [CW-1:0]        k_y,
    input  logic [CW-1:0]        k_z,
    input  logic signed [16:0]   angle,
    input  logic signed [15:0]   a_x,
    input  logic signed [15:0]   a_y,
    input  logic signed [15:0]   a_z,
    output logic                 v_out,
    output rot_t                 rot_out,
    output side_t                side_out
);

    logic [17:0] h;
    logic [14:0] rem;
    quad_t quad;
    logic [31:0] zprod;
    logic signed [31:0] px, py, pz, cx, cy, cz;
    logic v_reg;
    rot_t rot_reg;
    side_t side_reg, side_next;

    always_comb
    begin
        h = angle[16] ? 18'(19'(signed'(angle)) + 19'(TURN_UNITS)) : 18'(angle);
        if (h >= 18'(3 * QUARTER_UNITS))
        begin
            quad = QUAD_3;
            rem = 15'(h - 18'(3 * QUARTER_UNITS));
        end
        else if (h >= 18'(2 * QUARTER_UNITS))
        begin
            quad = QUAD_2;
            rem = 15'(h - 18'(2 * QUARTER_UNITS));
        end
        else if (h >= 18'(QUARTER_UNITS))
        begin
            quad = QUAD_1;
            rem = 15'(h - 18'(QUARTER_UNITS));
        end
        else
        begin
            quad = QUAD_0;
            rem = 15'(h);
        end
        zprod = 32'(rem) * 32'(RAD_PER_UNIT_Q30);
        px = 32'(signed'(p_x));
        py = 32'(signed'(p_y));
        pz = 32'(signed'(p_z));
        cx = 32'(signed'(k_x));
        cy = 32'(signed'(k_y));
        cz = 32'(signed'(k_z));
        side_next.quad = quad;
        side_next.d_x = 33'(px) - 33'(cx);
        side_next.d_y = 33'(py) - 33'(cy);
        side_next.d_z = 33'(pz) - 33'(cz);
        side_next.c_x = cx;
        side_next.c_y = cy;
        side_next.c_z = cz;
        side_next.a_x = a_x;
        side_next.a_y = a_y;
        side_next.a_z = a_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            rot_reg.x <= CORDIC_GAIN_Q30;
            rot_reg.y <= '0;
            rot_reg.z <= signed'({2'b00, zprod});
        end
    end

    assign v_out = v_reg;
    assign rot_out = rot_reg;
    assign side_out = side_reg;

endmodule

// File: rtl/qpr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpr_cell
// One rotator micro-rotation, registered, with its sideband carried along.
// ----------------------------------------------------------------------------
module qpr_cell
    import qpr_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  v_in,
    input  rot_t  rot_in,
    input  side_t side_in,
    output logic  v_out,
    output rot_t  rot_out,
    output side_t side_out
);

    logic v_reg;
    rot_t rot_reg, rot_next;
    side_t side_reg;

    always_comb
    begin
        if (!rot_in.z[33])
        begin
            rot_next.x = rot_in.x - (rot_in.y >>> STEP);
            rot_next.y = rot_in.y + (rot_in.x >>> STEP);
            rot_next.z = rot_in.z - atan_q30(STEP);
        end
        else
        begin
            rot_next.x = rot_in.x + (rot_in.y >>> STEP);
            rot_next.y = rot_in.y - (rot_in.x >>> STEP);
            rot_next.z = rot_in.z + atan_q30(STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg <= rot_next;
            side_reg <= side_in;
        end
    end

    assign v_out = v_reg;
    assign rot_out = rot_reg;
    assign side_out = side_reg;

endmodule

// File: rtl/qpr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpr_back
// Quadrant fold, axis scaling, two Hamilton products, recentre and saturate.
// ----------------------------------------------------------------------------
module qpr_back
    import qpr_pkg::*;
#(
    parameter int CW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          v_in,
    input  rot_t          rot_in,
    input  side_t         side_in,
    output logic          v_out,
    output logic [CW-1:0] r_x,
    output logic [CW-1:0] r_y,
    output logic [CW-1:0] r_z
);

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
    localparam logic signed [63:0] HALF24 = 64'sd1 <<< 23;

    // stage valids: trig, axis, products 1, sums 1, products 2, output
    logic [5:0] v_reg;

    // trig stage
    logic signed [33:0] xr, yr;
    logic signed [27:0] c0, s0, c_next, s_next, c1_reg, s1_reg;
    side_t side1_reg, side2_reg;

    // axis stage
    logic signed [27:0] c2_reg, u_reg [3];
    logic signed [43:0] us [3];

    // first products
    logic signed [60:0] pd_reg [12];
    logic signed [27:0] c3_reg, u3_reg [3];
    logic signed [31:0] ctr3_reg [3];

    // first sums
    logic signed [63:0] sm1 [4];
    logic signed [39:0] t_reg [4];
    logic signed [27:0] c4_reg, u4_reg [3];
    logic signed [31:0] ctr4_reg [3];

    // second products
    logic signed [63:0] pq_reg [12];
    logic signed [31:0] ctr5_reg [3];

    // output
    logic signed [63:0] sm2 [3];
    logic [CW-1:0] r_reg [3], r_next [3];

    always_comb
    begin
        xr = (rot_in.x + 34'sd32) >>> 6;
        yr = (rot_in.y + 34'sd32) >>> 6;
        c0 = xr[27:0];
        s0 = yr[27:0];
        case (side_in.quad)
            QUAD_0:
            begin
                c_next = c0;
                s_next = s0;
            end
            QUAD_1:
            begin
                c_next = -s0;
                s_next = c0;
            end
            QUAD_2:
            begin
                c_next = -c0;
                s_next = -s0;
            end
            default:
            begin
                c_next = s0;
                s_next = -c0;
            end
        endcase
        us[0] = 44'(side1_reg.a_x) * 44'(s1_reg);
        us[1] = 44'(side1_reg.a_y) * 44'(s1_reg);
        us[2] = 44'(side1_reg.a_z) * 44'(s1_reg);
        // tt, then the three vector terms of r * (0, d)
        sm1[0] = 64'(pd_reg[0]) + 64'(pd_reg[1]) + 64'(pd_reg[2]) + HALF24;
        sm1[1] = 64'(pd_reg[3]) - (64'(pd_reg[6]) - 64'(pd_reg[7])) + HALF24;
        sm1[2] = 64'(pd_reg[4]) - (64'(pd_reg[8]) - 64'(pd_reg[9])) + HALF24;
        sm1[3] = 64'(pd_reg[5]) - (64'(pd_reg[10]) - 64'(pd_reg[11])) + HALF24;
        for (int k = 0; k < 3; k++)
        begin
            sm2[k] = pq_reg[k] + pq_reg[3 + k] + (pq_reg[6 + 2 * k] - pq_reg[7 + 2 * k]);
            sm2[k] = ((sm2[k] + HALF24) >>> 24) + 64'(ctr5_reg[k]);
            if (sm2[k] > SAT_HI)
                r_next[k] = SAT_HI[CW-1:0];
            else if (sm2[k] < SAT_LO)
                r_next[k] = SAT_LO[CW-1:0];
            else
                r_next[k] = sm2[k][CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[4:0], v_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg <= c_next;
            s1_reg <= s_next;
            side1_reg <= side_in;

            c2_reg <= c1_reg;
            side2_reg <= side1_reg;
            for (int k = 0; k < 3; k++)
                u_reg[k] <= 28'((us[k] + 44'sd8192) >>> 14);

            pd_reg[0] <= 61'(u_reg[0]) * 61'(side2_reg.d_x);
            pd_reg[1] <= 61'(u_reg[1]) * 61'(side2_reg.d_y);
            pd_reg[2] <= 61'(u_reg[2]) * 61'(side2_reg.d_z);
            pd_reg[3] <= 61'(c2_reg) * 61'(side2_reg.d_x);
            pd_reg[4] <= 61'(c2_reg) * 61'(side2_reg.d_y);
            pd_reg[5] <= 61'(c2_reg) * 61'(side2_reg.d_z);
            pd_reg[6] <= 61'(u_reg[1]) * 61'(side2_reg.d_z);
            pd_reg[7] <= 61'(u_reg[2]) * 61'(side2_reg.d_y);
            pd_reg[8] <= 61'(u_reg[2]) * 61'(side2_reg.d_x);
            pd_reg[9] <= 61'(u_reg[0]) * 61'(side2_reg.d_z);
            pd_reg[10] <= 61'(u_reg[0]) * 61'(side2_reg.d_y);
            pd_reg[11] <= 61'(u_reg[1]) * 61'(side2_reg.d_x);
            c3_reg <= c2_reg;
            u3_reg <= u_reg;
            ctr3_reg[0] <= side2_reg.c_x;
            ctr3_reg[1] <= side2_reg.c_y;
            ctr3_reg[2] <= side2_reg.c_z;

            for (int k = 0; k < 4; k++)
                t_reg[k] <= 40'(sm1[k] >>> 24);
            c4_reg <= c3_reg;
            u4_reg <= u3_reg;
            ctr4_reg <= ctr3_reg;

            // tt*u, c*t, then cross terms t x u
            for (int k = 0; k < 3; k++)
            begin
                pq_reg[k] <= 64'(t_reg[0]) * 64'(u4_reg[k]);
                pq_reg[3 + k] <= 64'(c4_reg) * 64'(t_reg[1 + k]);
            end
            pq_reg[6] <= 64'(t_reg[2]) * 64'(u4_reg[2]);
            pq_reg[7] <= 64'(t_reg[3]) * 64'(u4_reg[1]);
            pq_reg[8] <= 64'(t_reg[3]) * 64'(u4_reg[0]);
            pq_reg[9] <= 64'(t_reg[1]) * 64'(u4_reg[2]);
            pq_reg[10] <= 64'(t_reg[1]) * 64'(u4_reg[1]);
            pq_reg[11] <= 64'(t_reg[2]) * 64'(u4_reg[0]);
            ctr5_reg <= ctr4_reg;

            r_reg <= r_next;
        end
    end

    assign v_out = v_reg[5];
    assign r_x = r_reg[0];
    assign r_y = r_reg[1];
    assign r_z = r_reg[2];

`ifndef SYNTHESIS
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline valids moved during stall");
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        v_out && !en |=> $stable(r_x) && $stable(r_y) && $stable(r_z))
        else $error("result changed during stall");
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && v_in |=> v_reg[0])
        else $error("item lost entering back end");
`endif

endmodule

// File: rtl/quaternion_point_rotation.sv
`timescale 1ns / 1ps
// Pipeline: 1 entry stage, 28 rotator cells and 6 back-end stages from input
//   transfer to result valid.
// Throughput: one point per cycle unless stalled by the single shared enable.
// Reset: clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_point_rotation
// Rotates a point about an axis through a centre using r*(0,P-C)*q.
// ----------------------------------------------------------------------------
module quaternion_point_rotation
    import qpr_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] point_x,
    input  logic [COORD_WIDTH-1:0] point_y,
    input  logic [COORD_WIDTH-1:0] point_z,
    input  logic [COORD_WIDTH-1:0] centre_x,
    input  logic [COORD_WIDTH-1:0] centre_y,
    input  logic [COORD_WIDTH-1:0] centre_z,
    input  logic signed [16:0]     angle_deg,
    input  logic signed [15:0]     axis_x,
    input  logic signed [15:0]     axis_y,
    input  logic signed [15:0]     axis_z,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_WIDTH-1:0] rotated_x,
    output logic [COORD_WIDTH-1:0] rotated_y,
    output logic [COORD_WIDTH-1:0] rotated_z
);

    // effective coordinate width: wider ports act as 32, narrower as 16
    localparam int CW = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 16) ? 16 : COORD_WIDTH);

    logic en;
    logic v_chain [CORDIC_STEPS + 1];
    rot_t rot_chain [CORDIC_STEPS + 1];
    side_t side_chain [CORDIC_STEPS + 1];
    logic [CW-1:0] r_x, r_y, r_z;

    // advance the whole pipe unless the finished result is held off
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    qpr_front #(.CW(CW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .v_in     (in_valid),
        .p_x      (point_x[CW-1:0]),
        .p_y      (point_y[CW-1:0]),
        .p_z      (point_z[CW-1:0]),
        .k_x      (centre_x[CW-1:0]),
        .k_y      (centre_y[CW-1:0]),
        .k_z      (centre_z[CW-1:0]),
        .angle    (angle_deg),
        .a_x      (axis_x),
        .a_y      (axis_y),
        .a_z      (axis_z),
        .v_out    (v_chain[0]),
        .rot_out  (rot_chain[0]),
        .side_out (side_chain[0])
    );

    // row of rotator cells, one micro-rotation each
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        qpr_cell #(.STEP(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (v_chain[i]),
            .rot_in   (rot_chain[i]),
            .side_in  (side_chain[i]),
            .v_out    (v_chain[i + 1]),
            .rot_out  (rot_chain[i + 1]),
            .side_out (side_chain[i + 1])
        );
    end

    qpr_back #(.CW(CW)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .v_in    (v_chain[CORDIC_STEPS]),
        .rot_in  (rot_chain[CORDIC_STEPS]),
        .side_in (side_chain[CORDIC_STEPS]),
        .v_out   (out_valid),
        .r_x     (r_x),
        .r_y     (r_y),
        .r_z     (r_z)
    );

    // results sit in the low CW bits
    assign rotated_x = COORD_WIDTH'(r_x);
    assign rotated_y = COORD_WIDTH'(r_y);
    assign rotated_z = COORD_WIDTH'(r_z);

endmodule
